// ===== sv/cukt_pkg.sv =====
// Shared types and codes for the compacting unique key table.
`default_nettype none

package cukt_pkg;

    localparam int KEY_W    = 32;
    localparam int POS_W    = 5;
    localparam int CNT_W    = 6;
    localparam int SLOT_MAX = 32;

    // Command kinds
    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_LIST   = 2'd3;

    // Result status codes
    localparam logic [2:0] STAT_ADDED    = 3'd0;
    localparam logic [2:0] STAT_DUP      = 3'd1;
    localparam logic [2:0] STAT_FULL     = 3'd2;
    localparam logic [2:0] STAT_REMOVED  = 3'd3;
    localparam logic [2:0] STAT_NOTFOUND = 3'd4;
    localparam logic [2:0] STAT_FOUND    = 3'd5;
    localparam logic [2:0] STAT_ENTRY    = 3'd6;
    localparam logic [2:0] STAT_EMPTY    = 3'd7;

    // Per-cell control from the table controller
    typedef struct packed {
        logic in_use;   // cell holds a live key
        logic tail;     // cell holds the last live key
        logic load;     // write command key (append)
        logic shift;    // remove pass: take neighbor key at/after the hit
        logic rot;      // list pass: rotate toward the head
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== sv/cukt_cell.sv =====
// One slot of the key chain: key register, compare, and neighbor hand-off.
`default_nettype none

module cukt_cell (
    input  wire logic                       i_clk,
    input  wire cukt_pkg::t_cell_ctl        i_ctl,
    input  wire logic [cukt_pkg::KEY_W-1:0] i_cmd_key,
    input  wire logic [cukt_pkg::KEY_W-1:0] i_nbr_key,
    input  wire logic [cukt_pkg::KEY_W-1:0] i_head_key,
    input  wire logic                       i_hit,
    output logic                            o_hit,
    output logic                            o_match,
    output logic [cukt_pkg::KEY_W-1:0]      o_key
);
    import cukt_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;

    assign o_match = i_ctl.in_use && (r_key == i_cmd_key);
    // hit seen here or in any cell toward the head
    assign o_hit   = i_hit | o_match;
    assign o_key   = r_key;

    always_comb begin
        n_key = r_key;
        if (i_ctl.load) begin
            n_key = i_cmd_key;
        end else if (i_ctl.shift && o_hit) begin
            n_key = i_nbr_key;
        end else if (i_ctl.rot) begin
            n_key = i_ctl.tail ? i_head_key : i_nbr_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

`default_nettype wire

// ===== sv/compacting_unique_key_table.sv =====
// Top level of the compacting unique key table: cell chain plus controller.
`default_nettype none

// A packed list of distinct 32-bit keys held in insertion order in a row of
// cells, one key per cell, with cell 0 at the head. Every cell compares its
// key against the command key in the same cycle, so lookup, add and remove
// each give one result beat. Remove shifts every cell at or after the hit
// one step toward the head in that same cycle. List walks the table by
// rotating the live cells toward the head once per output beat and reading
// cell 0; after entry_count beats the rotation is back where it started. A
// list command therefore gives one beat per live key (a single empty beat
// when the table is empty), and the input side is held off until its last
// beat has been loaded into the output register. The result register
// decouples the two sides, so a new command is taken while the previous
// result still waits, as long as it is being taken in that cycle or the
// register is empty. Usable capacity is CAPACITY clipped to 1..32. Add on a
// full table returns full; a key already present returns duplicate even
// when full.

module compacting_unique_key_table #(
    parameter int CAPACITY = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] key
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [31:0] key_out, [36:32] position,
                                             // [42:37] entry_count, [47:43] zero
    output logic [2:0]       m_axis_tuser,   // [2:0] status
    output logic             m_axis_tlast    // last beat of this command
);
    import cukt_pkg::*;

    localparam int DEPTH = (CAPACITY < 1) ? 1 :
                           ((CAPACITY > SLOT_MAX) ? SLOT_MAX : CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LIST = 2'b10
    } t_state;

    // control state
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [POS_W-1:0] r_idx,   n_idx;
    logic             r_m_valid, n_m_valid;

    // result register (payload)
    logic [2:0]       r_status, n_status;
    logic [KEY_W-1:0] r_key,    n_key;
    logic [POS_W-1:0] r_pos,    n_pos;
    logic [CNT_W-1:0] r_cnt,    n_cnt;
    logic             r_last,   n_last;

    // chain wiring
    t_cell_ctl        w_ctl  [DEPTH];
    logic [KEY_W-1:0] w_ckey [DEPTH];
    logic [DEPTH-1:0] w_match;
    logic [DEPTH:0]   w_hit;

    logic             in_beat;
    logic             out_free;
    logic             list_step;
    logic             hit_any;
    logic             full;
    logic             add_ok;
    logic [POS_W-1:0] hit_pos;
    logic [1:0]       cmd_kind;
    logic [KEY_W-1:0] cmd_key;

    assign cmd_kind  = s_axis_tuser;
    assign cmd_key   = s_axis_tdata;
    assign out_free  = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign list_step = (r_state == S_LIST) && out_free;

    assign w_hit[0]  = 1'b0;
    assign hit_any   = w_hit[DEPTH];
    assign full      = (r_count == CNT_W'(DEPTH));
    assign add_ok    = in_beat && (cmd_kind == KIND_ADD) && !hit_any && !full;

    // keys are distinct, so at most one match: OR the indices together
    always_comb begin
        hit_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_match[i]) begin
                hit_pos = hit_pos | POS_W'(i);
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [KEY_W-1:0] nbr;

        // last cell has no right neighbor; its value there is never live
        if (g == DEPTH - 1) begin : g_end
            assign nbr = w_ckey[0];
        end else begin : g_mid
            assign nbr = w_ckey[g + 1];
        end

        always_comb begin
            w_ctl[g].in_use = (CNT_W'(g) < r_count);
            w_ctl[g].tail   = (CNT_W'(g + 1) == r_count);
            w_ctl[g].load   = add_ok && (CNT_W'(g) == r_count);
            w_ctl[g].shift  = in_beat && (cmd_kind == KIND_REMOVE);
            w_ctl[g].rot    = list_step && w_ctl[g].in_use;
        end

        cukt_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl[g]),
            .i_cmd_key  (cmd_key),
            .i_nbr_key  (nbr),
            .i_head_key (w_ckey[0]),
            .i_hit      (w_hit[g]),
            .o_hit      (w_hit[g + 1]),
            .o_match    (w_match[g]),
            .o_key      (w_ckey[g])
        );
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_status  = r_status;
        n_key     = r_key;
        n_pos     = r_pos;
        n_cnt     = r_cnt;
        n_last    = r_last;

        if (in_beat) begin
            n_key  = cmd_key;
            n_pos  = '0;
            n_last = 1'b1;
            case (cmd_kind)
                KIND_LOOKUP: begin
                    n_m_valid = 1'b1;
                    n_status  = hit_any ? STAT_FOUND : STAT_NOTFOUND;
                    n_pos     = hit_any ? hit_pos : '0;
                    n_cnt     = r_count;
                end
                KIND_ADD: begin
                    n_m_valid = 1'b1;
                    if (hit_any) begin
                        n_status = STAT_DUP;
                        n_pos    = hit_pos;
                        n_cnt    = r_count;
                    end else if (full) begin
                        n_status = STAT_FULL;
                        n_cnt    = r_count;
                    end else begin
                        n_status = STAT_ADDED;
                        n_pos    = r_count[POS_W-1:0];
                        n_count  = r_count + CNT_W'(1);
                        n_cnt    = n_count;
                    end
                end
                KIND_REMOVE: begin
                    n_m_valid = 1'b1;
                    if (hit_any) begin
                        n_status = STAT_REMOVED;
                        n_pos    = hit_pos;
                        n_count  = r_count - CNT_W'(1);
                        n_cnt    = n_count;
                    end else begin
                        n_status = STAT_NOTFOUND;
                        n_cnt    = r_count;
                    end
                end
                KIND_LIST: begin
                    if (r_count == '0) begin
                        n_m_valid = 1'b1;
                        n_status  = STAT_EMPTY;
                        n_key     = '0;
                        n_cnt     = r_count;
                    end else begin
                        n_state = S_LIST;
                        n_idx   = '0;
                    end
                end
                default: begin
                    n_m_valid = r_m_valid && !m_axis_tready;
                end
            endcase
        end else if (list_step) begin
            // head cell holds entry r_idx; the chain rotates this cycle
            n_m_valid = 1'b1;
            n_status  = STAT_ENTRY;
            n_key     = w_ckey[0];
            n_pos     = r_idx;
            n_cnt     = r_count;
            n_last    = (CNT_W'(r_idx) + CNT_W'(1) == r_count);
            n_idx     = r_idx + POS_W'(1);
            if (n_last) begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_key    <= n_key;
        r_pos    <= n_pos;
        r_cnt    <= n_cnt;
        r_last   <= n_last;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {5'd0, r_cnt, r_pos, r_key};

    // occupancy never exceeds the cell count
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    // occupancy only moves on an accepted command
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_beat |=> $stable(r_count))
        else $error("entry count changed without a command");

    // the list walk ends exactly on the beat marked last
    a_list_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (list_step && n_last) |=> (r_state == S_IDLE) && r_m_valid && r_last)
        else $error("list walk did not close on its last beat");

    // no command taken while a list walk is running
    a_list_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> !in_beat)
        else $error("command accepted during list walk");

endmodule

`default_nettype wire

// ===== dv/tb_compacting_unique_key_table.sv =====
// Self-checking testbench for the compacting unique key table.
`default_nettype none

module tb_compacting_unique_key_table;
    timeunit 1ns;
    timeprecision 1ps;

    import cukt_pkg::*;

    localparam int TABLE_CAP      = 32;
    localparam int CYCLE_LIMIT    = 200000;  // far above the slowest legal run
    localparam int RX_HOLD_CYCLES = 400;     // long output back-pressure stretch
    localparam int DRAIN_CYCLES   = 40;
    localparam int RAND_PER_PHASE = 20;
    localparam int MAX_REPORTS    = 10;

    // One result beat, as seen on the master side.
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] key;
        logic [4:0]  pos;
        logic [5:0]  cnt;
        logic        last;
    } t_result;

    // One row of the directed table. Rows with typed set carry their result
    // written out by hand; the rest are checked against the predictor.
    typedef struct {
        logic [1:0]  kind;
        logic [31:0] key;
        bit          typed;
        logic [2:0]  status;
        logic [4:0]  pos;
        logic [5:0]  cnt;
    } t_cmd_row;

    localparam int N_ROWS = 22;
    t_cmd_row directed_rows [N_ROWS] = '{
        // empty table: list, lookup and remove all miss
        '{KIND_LIST,   32'h1234_5678, 1'b1, STAT_EMPTY,    5'd0, 6'd0},
        '{KIND_LOOKUP, 32'h0000_0000, 1'b1, STAT_NOTFOUND, 5'd0, 6'd0},
        '{KIND_REMOVE, 32'hFFFF_FFFF, 1'b1, STAT_NOTFOUND, 5'd0, 6'd0},
        // key extremes appended in order
        '{KIND_ADD,    32'h8000_0000, 1'b1, STAT_ADDED,    5'd0, 6'd1},
        '{KIND_ADD,    32'h7FFF_FFFF, 1'b1, STAT_ADDED,    5'd1, 6'd2},
        '{KIND_ADD,    32'h0000_0000, 1'b1, STAT_ADDED,    5'd2, 6'd3},
        '{KIND_ADD,    32'hFFFF_FFFF, 1'b1, STAT_ADDED,    5'd3, 6'd4},
        // duplicate reports the position already held
        '{KIND_ADD,    32'h7FFF_FFFF, 1'b1, STAT_DUP,      5'd1, 6'd4},
        '{KIND_LOOKUP, 32'h0000_0000, 1'b1, STAT_FOUND,    5'd2, 6'd4},
        '{KIND_LOOKUP, 32'h8000_0001, 1'b1, STAT_NOTFOUND, 5'd0, 6'd4},
        '{KIND_LIST,   32'hA5A5_A5A5, 1'b0, STAT_ENTRY,    5'd0, 6'd0},
        // remove from the middle, later keys close the gap
        '{KIND_REMOVE, 32'h7FFF_FFFF, 1'b1, STAT_REMOVED,  5'd1, 6'd3},
        '{KIND_LIST,   32'h0000_0000, 1'b0, STAT_ENTRY,    5'd0, 6'd0},
        '{KIND_LOOKUP, 32'hFFFF_FFFF, 1'b1, STAT_FOUND,    5'd2, 6'd3},
        // remove tail, then head, then the only key
        '{KIND_REMOVE, 32'hFFFF_FFFF, 1'b1, STAT_REMOVED,  5'd2, 6'd2},
        '{KIND_REMOVE, 32'h8000_0000, 1'b1, STAT_REMOVED,  5'd0, 6'd1},
        '{KIND_LOOKUP, 32'h0000_0000, 1'b1, STAT_FOUND,    5'd0, 6'd1},
        '{KIND_REMOVE, 32'h0000_0000, 1'b1, STAT_REMOVED,  5'd0, 6'd0},
        '{KIND_LIST,   32'hFFFF_FFFF, 1'b1, STAT_EMPTY,    5'd0, 6'd0},
        '{KIND_ADD,    32'h5555_AAAA, 1'b1, STAT_ADDED,    5'd0, 6'd1},
        '{KIND_ADD,    32'hAAAA_5555, 1'b1, STAT_ADDED,    5'd1, 6'd2},
        '{KIND_LIST,   32'h0F0F_F0F0, 1'b0, STAT_ENTRY,    5'd0, 6'd0}
    };

    // Clock and DUT-facing signals; those driven here are known from time zero.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] key
    logic [1:0]  s_axis_tuser = '0;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // [31:0] key_out, [36:32] position,
                                      // [42:37] entry_count, [47:43] zero
    logic [2:0]  m_axis_tuser;        // [2:0] status
    logic        m_axis_tlast;

    // Shadow copy of the table, updated on every accepted command beat.
    logic [31:0] table_keys [TABLE_CAP];
    int          table_count = 0;
    t_result     pending_results [$];

    int tx_idle_pct = 10;
    int rx_idle_pct = 72;
    bit rx_hold_req = 1'b0;
    bit rx_hold_taken = 1'b0;
    int mismatch_count = 0;
    int cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    compacting_unique_key_table #(
        .CAPACITY(TABLE_CAP)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Queue one expected beat; entry_count is always the count after the command.
    function automatic void push_result(logic [2:0] status, logic [31:0] key,
                                        int pos, bit last);
        t_result r;
        r.status = status;
        r.key    = key;
        r.pos    = pos[4:0];
        r.cnt    = table_count[5:0];
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    // Table behavior: one result for lookup/add/remove, one per key for list (one empty beat when empty).
    function automatic void apply_command(logic [1:0] kind, logic [31:0] key);
        int hit;
        hit = -1;
        for (int i = 0; i < table_count; i++)
            if (hit < 0 && table_keys[i] == key) hit = i;
        case (kind)
            KIND_LOOKUP: begin
                if (hit < 0) push_result(STAT_NOTFOUND, key, 0, 1'b1);
                else         push_result(STAT_FOUND, key, hit, 1'b1);
            end
            KIND_ADD: begin
                if (hit >= 0) begin
                    // a stored key wins over a full table
                    push_result(STAT_DUP, key, hit, 1'b1);
                end else if (table_count >= TABLE_CAP) begin
                    push_result(STAT_FULL, key, 0, 1'b1);
                end else begin
                    table_keys[table_count] = key;
                    table_count++;
                    push_result(STAT_ADDED, key, table_count - 1, 1'b1);
                end
            end
            KIND_REMOVE: begin
                if (hit < 0) begin
                    push_result(STAT_NOTFOUND, key, 0, 1'b1);
                end else begin
                    for (int i = hit + 1; i < table_count; i++)
                        table_keys[i - 1] = table_keys[i];
                    table_count--;
                    push_result(STAT_REMOVED, key, hit, 1'b1);
                end
            end
            default: begin
                // list ignores the command key; empty gives key 0
                if (table_count == 0) push_result(STAT_EMPTY, 32'h0, 0, 1'b1);
                for (int i = 0; i < table_count; i++)
                    push_result(STAT_ENTRY, table_keys[i], i, i + 1 == table_count);
            end
        endcase
    endfunction

    // Offer one command beat, with random idle cycles ahead of it. Returns
    // right after the accepting edge, with tvalid still high.
    task automatic send_command(logic [1:0] kind, logic [31:0] key);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        apply_command(kind, key);
    endtask

    // Sender pause: nothing new until every queued result has come back.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Key mix: half from the table (hits), most of the rest from a small pool
    // of both signs (duplicates, re-adds), the rest fully random.
    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && table_count > 0)
            return table_keys[$urandom_range(0, table_count - 1)];
        if (r < 8)
            return $urandom_range(0, 47) ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
        return $urandom;
    endfunction

    // Output side: random ready, plus one long hold-off when requested.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req && !rx_hold_taken) begin
                rx_hold_taken = 1'b1;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Result checker: every accepted beat against the oldest expectation.
    always @(posedge i_clk) begin : beat_check
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tuser;
            got.key    = m_axis_tdata[31:0];
            got.pos    = m_axis_tdata[36:32];
            got.cnt    = m_axis_tdata[42:37];
            got.last   = m_axis_tlast;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected beat: status %0d key %h pos %0d cnt %0d last %0b",
                             got.status, got.key, got.pos, got.cnt, got.last);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.key !== want.key ||
                    got.pos !== want.pos || got.cnt !== want.cnt ||
                    got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch: exp status %0d key %h pos %0d cnt %0d last %0b",
                                 want.status, want.key, want.pos, want.cnt, want.last);
                        $display("          got status %0d key %h pos %0d cnt %0d last %0b",
                                 got.status, got.key, got.pos, got.cnt, got.last);
                    end
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int add_pct;
        int w;
        logic [1:0] kind;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: sender idles lightly, receiver heavily.
        foreach (directed_rows[n]) begin
            send_command(directed_rows[n].kind, directed_rows[n].key);
            if (directed_rows[n].typed)
                pending_results[pending_results.size() - 1] = '{
                    directed_rows[n].status,
                    (directed_rows[n].kind == KIND_LIST) ? 32'h0 : directed_rows[n].key,
                    directed_rows[n].pos, directed_rows[n].cnt, 1'b1};
        end

        // Fill to capacity while the receiver holds off for a long stretch,
        // so the result register backs up and the input side stalls.
        rx_hold_req = 1'b1;
        for (int i = 0; table_count < TABLE_CAP; i++)
            send_command(KIND_ADD, 32'hC000_0000 + i * 32'h0001_0003);
        send_command(KIND_ADD, 32'h0BAD_F00D);       // full
        send_command(KIND_ADD, table_keys[5]);       // duplicate beats full
        send_command(KIND_LIST, 32'h0);              // longest list
        send_command(KIND_REMOVE, table_keys[10]);
        send_command(KIND_ADD, 32'h0BAD_F00D);       // lands in the top slot
        send_command(KIND_LOOKUP, table_keys[TABLE_CAP - 1]);
        send_command(KIND_REMOVE, table_keys[TABLE_CAP - 1]);
        send_command(KIND_REMOVE, table_keys[0]);
        wait_results_drained();

        // Random phases: light/heavy idling, then swapped, then none.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 10; rx_idle_pct = 72; add_pct = 35; end
                1: begin tx_idle_pct = 72; rx_idle_pct = 10; add_pct = 55; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; add_pct = 35; end
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                w = $urandom_range(0, 99);
                if (w < add_pct)           kind = KIND_ADD;
                else if (w < add_pct + 10) kind = KIND_LIST;
                else if (w < add_pct + 35) kind = KIND_REMOVE;
                else                       kind = KIND_LOOKUP;
                send_command(kind, (kind == KIND_LIST) ? $urandom : pick_key());
            end
            wait_results_drained();
        end

        // Quiet tail: any stray beat here is caught by the checker.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/cukt_pkg.sv
sv/cukt_cell.sv
sv/compacting_unique_key_table.sv
dv/tb_compacting_unique_key_table.sv
